[hdl/paged_mono_framebuffer_blitter_unit_macros.svh]
// Assertion macros shared by the frame buffer blitter RTL.
`ifndef PAGED_MONO_FRAMEBUFFER_BLITTER_UNIT_MACROS_SVH
`define PAGED_MONO_FRAMEBUFFER_BLITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define PMFB_ASSERT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("pmfb: same-cycle check failed");

`define PMFB_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("pmfb: next-cycle check failed");

`else

`define PMFB_ASSERT(label, clock, resetn, ante, cons)

`define PMFB_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

[hdl/pmfb_pkg.sv]
// Shared constants, request codes and controller/datapath interface types.
`default_nettype none

package pmfb_pkg;

    localparam int DEF_SCREEN_COLUMNS = 128;
    localparam int DEF_SCREEN_ROWS    = 64;

    // wide enough for any row limit in the supported parameter range
    localparam int LIMIT_W = 9;

    localparam logic [6:0] VIEWPORT_RESET = 7'd56;
    localparam logic [3:0] BITMAP_MAX     = 4'd8;

    localparam logic [2:0] REQ_PIXEL  = 3'd0;
    localparam logic [2:0] REQ_BYTE   = 3'd1;
    localparam logic [2:0] REQ_BITMAP = 3'd2;
    localparam logic [2:0] REQ_INVERT = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    typedef struct packed {
        logic load;     // capture a new request, rewind step counter
        logic issue;    // issue one read-modify-write step
        logic deliver;  // move the finished result into the output register
    } pmfb_cmd_t;

    typedef struct packed {
        logic last_step;    // current step is the last of the request
        logic sweep_clear;  // running the post-reset clearing pass
    } pmfb_stat_t;

endpackage

`default_nettype wire

[hdl/pmfb_dp.sv]
// Datapath: frame store memory, step address generation, clipping and result registers.
`default_nettype none
`include "paged_mono_framebuffer_blitter_unit_macros.svh"

module pmfb_dp #(
    parameter int SCREEN_COLUMNS = pmfb_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = pmfb_pkg::DEF_SCREEN_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pmfb_pkg::pmfb_cmd_t  cmd,
    output pmfb_pkg::pmfb_stat_t stat,
    input  logic [2:0]         req_type,
    input  logic signed [7:0]  x_pos,
    input  logic signed [7:0]  y_pos,
    input  logic               color,
    input  logic               clip_viewport,
    input  logic [7:0]         data_byte,
    input  logic [3:0]         bit_count,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data,
    output logic [7:0]         read_data,
    output logic               status
);
    import pmfb_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_ROWS + 7) / 8;
    localparam int STORE_BYTES = SCREEN_COLUMNS * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
    localparam logic [LIMIT_W-1:0] ROW_LIMIT = LIMIT_W'(SCREEN_ROWS);
    localparam logic [9:0]         COL_LIMIT = 10'(SCREEN_COLUMNS);

    typedef enum logic [2:0] {
        OP_PIXEL,
        OP_BYTE,
        OP_BITMAP,
        OP_INVERT,
        OP_READ,
        OP_NONE,
        OP_CLEAR
    } op_t;

    logic [7:0] mem [STORE_BYTES];

    op_t               op_reg, op_next;
    logic signed [7:0] x_reg, y_reg;
    logic              color_reg, clip_reg;
    logic [7:0]        data_reg;
    logic [3:0]        count_reg, count_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic [ADDR_W-1:0] idx_reg;
    logic              hit_reg;
    logic [7:0]        res_data_reg;
    logic [6:0]        vp_reg;

    logic              s2_valid_reg, s2_we_reg, s2_cap_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [7:0]        rdata_reg;

    logic [7:0]        read_data_reg;
    logic              status_reg, status_next;

    // step address and clipping
    logic [9:0]         cx;
    logic               x_ok, y_ok, on_scr, count_ok, step_hit, we_cond, cap_cond;
    logic [LIMIT_W-1:0] vp_lim, row_lim;
    logic [15:0]        addr_wide;
    logic [ADDR_W-1:0]  issue_addr;
    logic [7:0]         pix_bit, wdata;

    always_comb
    begin
        count_next = (bit_count > BITMAP_MAX) ? BITMAP_MAX : bit_count;
        unique case (req_type)
            REQ_PIXEL:  op_next = OP_PIXEL;
            REQ_BYTE:   op_next = OP_BYTE;
            REQ_BITMAP: op_next = OP_BITMAP;
            REQ_INVERT: op_next = OP_INVERT;
            REQ_READ:   op_next = OP_READ;
            default:    op_next = OP_NONE;
        endcase
        case (op_next)
            OP_BITMAP: last_next = (count_next == 4'd0) ? '0 : ADDR_W'(count_next - 4'd1);
            OP_INVERT: last_next = LAST_ADDR;
            default:   last_next = '0;
        endcase
    end

    always_comb
    begin
        cx       = {{2{x_reg[7]}}, x_reg} + {7'd0, idx_reg[2:0]};
        x_ok     = !cx[9] && (cx < COL_LIMIT);
        vp_lim   = {2'b00, vp_reg};
        row_lim  = (op_reg == OP_PIXEL && clip_reg && vp_lim < ROW_LIMIT) ? vp_lim : ROW_LIMIT;
        y_ok     = !y_reg[7] && ({2'b00, y_reg[6:0]} < row_lim);
        on_scr   = x_ok && y_ok;
        count_ok = (op_reg != OP_BITMAP) || ({1'b0, idx_reg[2:0]} < count_reg);

        case (op_reg) inside
            OP_PIXEL, OP_BYTE, OP_BITMAP, OP_READ: step_hit = on_scr && count_ok;
            default:                               step_hit = 1'b0;
        endcase

        case (op_reg) inside
            OP_PIXEL, OP_BYTE:   we_cond = step_hit;
            OP_BITMAP:           we_cond = step_hit && data_reg[3'd7 - idx_reg[2:0]];
            OP_INVERT, OP_CLEAR: we_cond = 1'b1;
            default:             we_cond = 1'b0;
        endcase
        cap_cond = (op_reg == OP_READ) && step_hit;

        addr_wide = 16'(y_reg[6:3]) * 16'(SCREEN_COLUMNS) + 16'(cx[8:0]);
        case (op_reg) inside
            OP_INVERT, OP_CLEAR: issue_addr = idx_reg;
            default:             issue_addr = addr_wide[ADDR_W-1:0];
        endcase
    end

    // modify stage, works on the byte read in the previous cycle
    always_comb
    begin
        pix_bit = 8'd1 << y_reg[2:0];
        case (op_reg) inside
            OP_PIXEL, OP_BITMAP: wdata = color_reg ? (rdata_reg | pix_bit)
                                                   : (rdata_reg & ~pix_bit);
            OP_BYTE:             wdata = data_reg;
            OP_INVERT:           wdata = ~rdata_reg;
            default:             wdata = 8'd0;
        endcase
        case (op_reg) inside
            OP_PIXEL, OP_BYTE, OP_BITMAP, OP_READ: status_next = !hit_reg;
            default:                               status_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_we_reg)
        begin
            mem[s2_addr_reg] <= wdata;
        end
        if (cmd.issue)
        begin
            rdata_reg <= mem[issue_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= OP_CLEAR;
            last_reg     <= LAST_ADDR;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            vp_reg       <= VIEWPORT_RESET;
            s2_valid_reg <= 1'b0;
            s2_we_reg    <= 1'b0;
            s2_cap_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vp_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                op_reg   <= op_next;
                last_reg <= last_next;
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= (idx_reg == last_reg) ? '0 : idx_reg + 1'b1;
                hit_reg <= hit_reg | step_hit;
            end
            s2_valid_reg <= cmd.issue;
            s2_we_reg    <= cmd.issue && we_cond;
            s2_cap_reg   <= cmd.issue && cap_cond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg        <= x_pos;
            y_reg        <= y_pos;
            color_reg    <= color;
            clip_reg     <= clip_viewport;
            data_reg     <= data_byte;
            count_reg    <= count_next;
            res_data_reg <= 8'd0;
        end
        else if (s2_valid_reg && s2_cap_reg)
        begin
            res_data_reg <= rdata_reg;
        end
        if (cmd.issue)
        begin
            s2_addr_reg <= issue_addr;
        end
        if (cmd.deliver)
        begin
            read_data_reg <= res_data_reg;
            status_reg    <= status_next;
        end
    end

    assign stat.last_step   = (idx_reg == last_reg);
    assign stat.sweep_clear = (op_reg == OP_CLEAR);
    assign read_data        = read_data_reg;
    assign status           = status_reg;

    `PMFB_ASSERT(a_we_in_retire, clk, rst_n, s2_we_reg, s2_valid_reg)
    `PMFB_ASSERT(a_load_drained, clk, rst_n, cmd.load, !s2_valid_reg)
    `PMFB_ASSERT(a_bitmap_span, clk, rst_n, cmd.issue && op_reg == OP_BITMAP, idx_reg < ADDR_W'(8))
    `PMFB_ASSERT_NEXT(a_read_only_data, clk, rst_n, cmd.deliver && op_reg != OP_READ, read_data_reg == 8'd0)

endmodule

`default_nettype wire

[hdl/pmfb_ctrl.sv]
// Controller: sequences clear sweep, request steps, drain and result hand-off.
`default_nettype none
`include "paged_mono_framebuffer_blitter_unit_macros.svh"

module pmfb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pmfb_pkg::pmfb_stat_t stat,
    output pmfb_pkg::pmfb_cmd_t  cmd
);
    import pmfb_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_DRAIN,
        S_DONE,
        S_IDLE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        slot_free      = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_RUN:
            begin
                cmd.issue = 1'b1;
                if (stat.last_step)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last write retires this cycle
                state_next = stat.sweep_clear ? S_IDLE : S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.deliver    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;   // clearing pass starts out of reset
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `PMFB_ASSERT(a_clear_no_result, clk, rst_n, state_reg == S_DONE, !stat.sweep_clear)
    `PMFB_ASSERT_NEXT(a_deliver_shows, clk, rst_n, cmd.deliver, out_valid_reg)
    `PMFB_ASSERT_NEXT(a_drain_exit, clk, rst_n, state_reg == S_DRAIN, state_reg == S_IDLE || state_reg == S_DONE)

endmodule

`default_nettype wire

[hdl/paged_mono_framebuffer_blitter_unit.sv]
// Flow: a request is accepted in IDLE, steps through RUN, then DRAIN and DONE; out_valid is
// registered when DONE delivers. Bitmap: one RUN step per bit, at least one, bit_count clamped to 8;
// invert: one RUN step per store byte. One store read-modify-write per cycle while in RUN.
// A finished result waits in the output register while the next request is accepted.
// Reset: asynchronous; a clearing pass writes zeros over all store bytes, in_ready low
// until the pass ends; the viewport register resets to 56.
`default_nettype none

module paged_mono_framebuffer_blitter_unit #(
    parameter int SCREEN_COLUMNS = pmfb_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = pmfb_pkg::DEF_SCREEN_ROWS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        req_type,
    input  logic signed [7:0] x_pos,
    input  logic signed [7:0] y_pos,
    input  logic              color,
    input  logic              clip_viewport,
    input  logic [7:0]        data_byte,
    input  logic [3:0]        bit_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        read_data,
    output logic              status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [6:0]        viewport_height
);
    import pmfb_pkg::*;

    pmfb_cmd_t  cmd;
    pmfb_stat_t stat;

    // config transaction always taken; to be written only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    pmfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pmfb_dp #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .color         (color),
        .clip_viewport (clip_viewport),
        .data_byte     (data_byte),
        .bit_count     (bit_count),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (viewport_height),
        .read_data     (read_data),
        .status        (status)
    );

endmodule

`default_nettype wire

[sim/paged_mono_framebuffer_blitter_unit_tb.sv]
// Self-checking testbench for the paged monochrome frame buffer blitter unit.
`default_nettype none

module paged_mono_framebuffer_blitter_unit_tb;

    import pmfb_pkg::*;

    localparam int COLS        = DEF_SCREEN_COLUMNS;
    localparam int ROWS        = DEF_SCREEN_ROWS;
    localparam int STORE_BYTES = COLS * ((ROWS + 7) / 8);

    // codes the block must answer with a plain done
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 195;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX  = 10;

    typedef enum logic { JOB_REQ, JOB_CFG } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [2:0] req;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
        logic       clip;
        logic [7:0] data;
        logic [3:0] count;
        logic [6:0] vp;
    } job_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       st;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] req_type = '0;
    logic signed [7:0] x_pos = '0;
    logic signed [7:0] y_pos = '0;
    logic       color = 1'b0;
    logic       clip_viewport = 1'b0;
    logic [7:0] data_byte = '0;
    logic [3:0] bit_count = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic       status;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] viewport_height = VIEWPORT_RESET;

    job_t    pending_jobs[$];
    answer_t expected_answers[$];
    job_t    cur_job;

    // shadow of the frame store and the viewport register
    logic [7:0] pixel_bytes [0:STORE_BYTES-1];
    logic [6:0] vp_shadow;

    int err_count = 0;

    paged_mono_framebuffer_blitter_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .x_pos           (x_pos),
        .y_pos           (y_pos),
        .color           (color),
        .clip_viewport   (clip_viewport),
        .data_byte       (data_byte),
        .bit_count       (bit_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .viewport_height (viewport_height)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit on_screen(input int cx, input int cy, input int row_limit);
        return cx >= 0 && cx < COLS && cy >= 0 && cy < row_limit;
    endfunction

    function automatic int store_addr(input int cx, input int cy);
        return (cy >>> 3) * COLS + cx;
    endfunction

    task automatic paint_pixel(input int cx, input int cy, input logic white);
        int a;
        a = store_addr(cx, cy);
        pixel_bytes[a][cy & 7] = white;
    endtask

    // Update the shadow store for one request and give back its answer.
    task automatic render_request(input job_t j, output answer_t ans);
        int x;
        int y;
        int lim;
        int cnt;
        bit hit;
        x = int'($signed(j.x));
        y = int'($signed(j.y));
        ans = '0;
        case (j.req)
            REQ_PIXEL:
            begin
                lim = ROWS;
                if (j.clip && int'(vp_shadow) < lim)
                    lim = int'(vp_shadow);
                if (on_screen(x, y, lim))
                    paint_pixel(x, y, j.color);
                else
                    ans.st = 1'b1;
            end
            REQ_BYTE:
            begin
                if (on_screen(x, y, ROWS))
                    pixel_bytes[store_addr(x, y)] = j.data;
                else
                    ans.st = 1'b1;
            end
            REQ_BITMAP:
            begin
                cnt = (j.count > BITMAP_MAX) ? int'(BITMAP_MAX) : int'(j.count);
                hit = 1'b0;
                for (int i = 0; i < cnt; i++)
                begin
                    if (on_screen(x + i, y, ROWS))
                    begin
                        hit = 1'b1;
                        if (j.data[7 - i])
                            paint_pixel(x + i, y, j.color);
                    end
                end
                ans.st = !hit;
            end
            REQ_INVERT:
            begin
                for (int a = 0; a < STORE_BYTES; a++)
                    pixel_bytes[a] = ~pixel_bytes[a];
            end
            REQ_READ:
            begin
                if (on_screen(x, y, ROWS))
                    ans.rd = pixel_bytes[store_addr(x, y)];
                else
                    ans.st = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    // Mostly short gaps, a few long ones, none at all while calm.
    function automatic int idle_span(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic job_t req_job(input logic [2:0] rq, input logic [7:0] cx,
                                     input logic [7:0] cy, input logic white,
                                     input logic vp_clip, input logic [7:0] d,
                                     input logic [3:0] n);
        job_t j;
        j.kind  = JOB_REQ;
        j.req   = rq;
        j.x     = cx;
        j.y     = cy;
        j.color = white;
        j.clip  = vp_clip;
        j.data  = d;
        j.count = n;
        j.vp    = '0;
        return j;
    endfunction

    function automatic job_t cfg_job(input logic [6:0] v);
        job_t j;
        j = '0;
        j.kind = JOB_CFG;
        j.vp   = v;
        return j;
    endfunction

    // Driver: request and configuration channels.
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        bit      req_busy;
        bit      wr_busy;
        int      gap_left;
        bit      calm;
        answer_t ans;
        job_t    nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            for (int a = 0; a < STORE_BYTES; a++)
                pixel_bytes[a] = 8'h00;
            vp_shadow = VIEWPORT_RESET;
            gap_left = 0;
            calm = 1'b0;
        end
        else
        begin
            req_busy = in_valid;
            wr_busy  = cfg_valid;
            if (in_valid && in_ready)
            begin
                render_request(cur_job, ans);
                expected_answers.push_back(ans);
                req_busy = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                vp_shadow = viewport_height;
                wr_busy = 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            if (!req_busy && !wr_busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_jobs.size() > 0)
                begin
                    nxt = pending_jobs[0];
                    if (nxt.kind == JOB_CFG)
                    begin
                        // register writes only once the block has drained
                        if (expected_answers.size() == 0)
                        begin
                            void'(pending_jobs.pop_front());
                            viewport_height <= nxt.vp;
                            wr_busy = 1'b1;
                            gap_left = idle_span(calm);
                        end
                    end
                    else
                    begin
                        void'(pending_jobs.pop_front());
                        cur_job       = nxt;
                        req_type      <= nxt.req;
                        x_pos         <= nxt.x;
                        y_pos         <= nxt.y;
                        color         <= nxt.color;
                        clip_viewport <= nxt.clip;
                        data_byte     <= nxt.data;
                        bit_count     <= nxt.count;
                        req_busy = 1'b1;
                        gap_left = idle_span(calm);
                    end
                end
            end
            in_valid  <= req_busy;
            cfg_valid <= wr_busy;
        end
    end

    // Monitor: result channel with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : watch_blk
        int      stall_left;
        bit      calm;
        answer_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            calm = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected result: read_data %02h status %0d",
                                 read_data, status);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (read_data !== want.rd || status !== want.st)
                    begin
                        err_count++;
                        if (err_count <= REPORT_MAX)
                            $display("mismatch: read_data exp %02h got %02h, status exp %0d got %0d",
                                     want.rd, read_data, want.st, status);
                    end
                end
            end
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ((out_valid && out_ready) || $urandom_range(0, 15) == 0)
                    stall_left = idle_span(calm);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stim_blk
        logic [6:0] phase_vp [0:5];
        logic [6:0] cur_vp;
        job_t       j;
        int         r;
        int         edge_y;

        phase_vp[0] = 7'd1;
        phase_vp[1] = 7'd64;
        phase_vp[2] = 7'd0;
        phase_vp[3] = 7'd127;
        phase_vp[4] = 7'd63;
        phase_vp[5] = 7'd57;

        // directed: store cleared, clipping edges, bitmap edges, invert, unknown codes
        pending_jobs.push_back(req_job(REQ_READ,   0,     0,     0, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_PIXEL,  0,     0,     1, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_PIXEL,  127,   63,    1, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_PIXEL,  8'hFF, 0,     1, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_PIXEL,  8'h80, 8'h80, 1, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_PIXEL,  10,    55,    1, 1, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_PIXEL,  10,    56,    1, 1, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_BYTE,   127,   56,    0, 0, 8'hFF, 4'd0));
        pending_jobs.push_back(req_job(REQ_BYTE,   0,     8'hFF, 0, 0, 8'hA5, 4'd0));
        pending_jobs.push_back(req_job(REQ_BYTE,   5,     8,     0, 0, 8'hA5, 4'd0));
        pending_jobs.push_back(req_job(REQ_BITMAP, 124,   10,    1, 0, 8'hFF, 4'd8));
        pending_jobs.push_back(req_job(REQ_BITMAP, 8'hFD, 11,    1, 0, 8'hFF, 4'd8));
        pending_jobs.push_back(req_job(REQ_BITMAP, 8'hF8, 12,    1, 0, 8'hFF, 4'd8));
        pending_jobs.push_back(req_job(REQ_BITMAP, 20,    12,    1, 0, 8'hFF, 4'd0));
        pending_jobs.push_back(req_job(REQ_BITMAP, 30,    13,    1, 0, 8'hC3, 4'd15));
        pending_jobs.push_back(req_job(REQ_BITMAP, 0,     64,    1, 0, 8'hFF, 4'd8));
        pending_jobs.push_back(req_job(REQ_BITMAP, 120,   10,    0, 0, 8'hAA, 4'd5));
        pending_jobs.push_back(req_job(REQ_INVERT, 0,     0,     0, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_READ,   127,   8,     0, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_INVERT, 0,     0,     0, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_READ,   127,   63,    0, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_READ,   0,     64,    0, 0, 8'h00, 4'd0));
        pending_jobs.push_back(req_job(REQ_UNUSED_LO, 1, 1,    1, 1, 8'hFF, 4'd8));
        pending_jobs.push_back(req_job(REQ_UNUSED_HI, 1, 1,    1, 1, 8'hFF, 4'd8));
        pending_jobs.push_back(cfg_job(7'd0));
        pending_jobs.push_back(req_job(REQ_PIXEL,  0,     0,     1, 1, 8'h00, 4'd0));
        cur_vp = 7'd0;

        for (int p = 0; p < PHASES; p++)
        begin
            cur_vp = (p < 6) ? phase_vp[p] : 7'($urandom_range(0, 127));
            pending_jobs.push_back(cfg_job(cur_vp));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                j = '0;
                j.kind  = JOB_REQ;
                j.color = 1'($urandom_range(0, 1));
                j.clip  = 1'($urandom_range(0, 1));
                j.data  = 8'($urandom);
                j.count = 4'($urandom_range(1, 8));
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    j.x = 8'($urandom);
                    j.y = 8'($urandom);
                end
                else if (r < 45)
                begin
                    j.x = 8'($urandom_range(0, 15));
                    j.y = 8'($urandom_range(0, 15));
                end
                else
                begin
                    j.x = 8'($urandom_range(0, COLS - 1));
                    j.y = 8'($urandom_range(0, ROWS - 1));
                end
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    j.req = REQ_PIXEL;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        // rows around the viewport edge
                        edge_y = int'(cur_vp) + int'($urandom_range(0, 2)) - 1;
                        j.y = 8'(edge_y);
                        j.clip = 1'b1;
                    end
                end
                else if (r < 45)
                    j.req = REQ_BYTE;
                else if (r < 70)
                begin
                    j.req = REQ_BITMAP;
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        j.x = 8'($urandom_range(COLS - 8, COLS - 1));
                    else if (r == 1)
                        j.x = 8'(-int'($urandom_range(1, 8)));
                    else if (r == 2)
                        j.count = 4'($urandom_range(0, 15));
                end
                else if (r < 95)
                    j.req = REQ_READ;
                else if (r < 97)
                    j.req = REQ_INVERT;
                else
                    j.req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                pending_jobs.push_back(j);
            end
        end
        // leave the register at its reset value at the end
        pending_jobs.push_back(cfg_job(VIEWPORT_RESET));

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_jobs.size() != 0 || in_valid || cfg_valid ||
               expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
